>>> rtl/core/vlof_pkg.sv
// ============================================================================
// vlof_pkg: shared types, constants and functions of the voxel fusion block
// Holds register defaults, register indexes, the controller state type and
// the elaboration-time function that fills the logit table.
// ============================================================================
package vlof_pkg;

    // Default values of the top-level parameters.
    localparam int VOXEL_ADDR_BITS_DEF  = 16;
    localparam int LABEL_BITS_DEF       = 8;
    localparam int LOGIT_TABLE_BITS_DEF = 10;

    // Configuration port.
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // Register reset values.
    localparam logic [15:0]        LABEL_STEP_RST   = 16'd128;
    localparam logic [15:0]        WEIGHT_CAP_RST   = 16'd65535;
    localparam logic [15:0]        OCC_PROB_RST     = 16'd45875;
    localparam logic [15:0]        FREE_PROB_RST    = 16'd26214;
    localparam logic signed [15:0] MIN_LOG_ODDS_RST = -16'sd512;
    localparam logic signed [15:0] MAX_LOG_ODDS_RST = 16'sd896;

    // One half in Q0.16 and the rounding constant of the probability blend.
    localparam logic signed [34:0] BLEND_BIAS = 35'sd1073758208; // 2^30 + 2^14
    localparam logic [16:0]        HALF_Q16   = 17'd32768;

    // ln(2) in Q0.16.
    localparam logic signed [63:0] LN2_Q16 = 64'sd45426;

    typedef enum logic [2:0] {
        REG_LABEL_STEP   = 3'd0,
        REG_WEIGHT_CAP   = 3'd1,
        REG_OCC_PROB     = 3'd2,
        REG_FREE_PROB    = 3'd3,
        REG_MIN_LOG_ODDS = 3'd4,
        REG_MAX_LOG_ODDS = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_WRITE
    } vlof_state_t;

    // Integer log2 with 16 fraction bits, by repeated squaring (truncating).
    function automatic logic [63:0] log2_q16(input logic [31:0] x);
        logic [31:0] t;
        int          e;
        logic [63:0] y;
        logic [63:0] r;
        t = x;
        e = 0;
        r = '0;
        y = '0;
        if (x != 32'd0)
        begin
            for (int k = 0; k < 32; k++)
            begin
                if (t > 32'd1)
                begin
                    t = t >> 1;
                    e++;
                end
            end
            y = ({32'd0, x} << 30) >> e;
            r = 64'(e) << 16;
            for (int bi = 15; bi >= 0; bi--)
            begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30))
                begin
                    y = y >> 1;
                    r = r + (64'd1 << bi);
                end
            end
        end
        return r;
    endfunction

    // Logit of the midpoint of bin idx, rounded half away from zero to Q8.8.
    function automatic logic signed [15:0] logit_entry(input int idx, input int tbits);
        logic [31:0]        a;
        logic [31:0]        b;
        logic signed [63:0] v;
        logic [63:0]        mag;
        logic signed [63:0] q;
        a   = 32'(2 * idx + 1);
        b   = (32'd1 << (tbits + 1)) - a;
        v   = ($signed(log2_q16(a)) - $signed(log2_q16(b))) * LN2_Q16;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        q   = $signed((mag + (64'd1 << 23)) >> 24);
        if (v < 0)
        begin
            q = -q;
        end
        if (q > 64'sd32767)
        begin
            q = 64'sd32767;
        end
        if (q < -64'sd32768)
        begin
            q = -64'sd32768;
        end
        return q[15:0];
    endfunction

endpackage

>>> rtl/core/vlof_ram.sv
// ============================================================================
// vlof_ram: generic simple dual-port RAM with registered read
// One write port and one read port; read data appears in the cycle after the
// read enable.
// ============================================================================
module vlof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/voxel_label_occupancy_fusion.sv
// ============================================================================
// voxel_label_occupancy_fusion: semantic label and log-odds occupancy update
// Keeps one word per voxel (label, label weight, log-odds, observed flag) in
// a synchronous RAM and updates it by read-modify-write for each transfer.
// ============================================================================
// After an input transfer the voxel passes the fusion and write-back states;
// the result then sits in an output register until it is taken.
// The RAM read, the fusion stage and the write-back of one voxel finish
// before the next input is taken.
// Reset: the configuration registers return to their defaults and the voxel
// RAM is swept to zero before the first input transfer.
module voxel_label_occupancy_fusion #(
    parameter int VOXEL_ADDR_BITS  = vlof_pkg::VOXEL_ADDR_BITS_DEF,
    parameter int LABEL_BITS       = vlof_pkg::LABEL_BITS_DEF,
    parameter int LOGIT_TABLE_BITS = vlof_pkg::LOGIT_TABLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vlof_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [vlof_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [vlof_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    // Input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [VOXEL_ADDR_BITS-1:0]         voxel_addr,
    input  logic [LABEL_BITS-1:0]              pred_class,
    input  logic [15:0]                        obs_weight,
    // Output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [VOXEL_ADDR_BITS-1:0]         out_addr,
    output logic [LABEL_BITS-1:0]              out_label,
    output logic [15:0]                        out_label_weight,
    output logic signed [15:0]                 out_log_odds,
    output logic                               was_observed
);

    import vlof_pkg::*;

    // Each RAM word packs {observed, log-odds, weight, label}.
    localparam int WORD_BITS = LABEL_BITS + 33;
    localparam int DEPTH     = 1 << VOXEL_ADDR_BITS;
    localparam int ROM_DEPTH = 1 << LOGIT_TABLE_BITS;

    // ------------------------------------------------------------------
    // Configuration registers. A write completes in the access phase;
    // pready is tied high so every access completes without wait states.
    // ------------------------------------------------------------------
    logic [15:0]        label_step_reg;
    logic [15:0]        weight_cap_reg;
    logic [15:0]        occ_prob_reg;
    logic [15:0]        free_prob_reg;
    logic signed [15:0] min_lo_reg;
    logic signed [15:0] max_lo_reg;
    logic               cfg_write;
    cfg_index_t         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = cfg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_step_reg <= LABEL_STEP_RST;
            weight_cap_reg <= WEIGHT_CAP_RST;
            occ_prob_reg   <= OCC_PROB_RST;
            free_prob_reg  <= FREE_PROB_RST;
            min_lo_reg     <= MIN_LOG_ODDS_RST;
            max_lo_reg     <= MAX_LOG_ODDS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_LABEL_STEP:   label_step_reg <= pwdata[15:0];
                REG_WEIGHT_CAP:   weight_cap_reg <= pwdata[15:0];
                REG_OCC_PROB:     occ_prob_reg   <= pwdata[15:0];
                REG_FREE_PROB:    free_prob_reg  <= pwdata[15:0];
                REG_MIN_LOG_ODDS: min_lo_reg     <= $signed(pwdata[15:0]);
                REG_MAX_LOG_ODDS: max_lo_reg     <= $signed(pwdata[15:0]);
                default:          ;
            endcase
        end
    end

    // Read data: signed registers come back sign-extended.
    always_comb
    begin
        unique case (cfg_idx)
            REG_LABEL_STEP:   prdata = {16'd0, label_step_reg};
            REG_WEIGHT_CAP:   prdata = {16'd0, weight_cap_reg};
            REG_OCC_PROB:     prdata = {16'd0, occ_prob_reg};
            REG_FREE_PROB:    prdata = {16'd0, free_prob_reg};
            REG_MIN_LOG_ODDS: prdata = {{16{min_lo_reg[15]}}, min_lo_reg};
            REG_MAX_LOG_ODDS: prdata = {{16{max_lo_reg[15]}}, max_lo_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Logit table, built at elaboration. Entry i is the log-odds of the
    // midpoint of probability bin i, in Q8.8.
    // ------------------------------------------------------------------
    logic signed [15:0] logit_rom [ROM_DEPTH];

    for (genvar gi = 0; gi < ROM_DEPTH; gi++)
    begin : g_logit_rom
        localparam logic signed [15:0] ENTRY = logit_entry(gi, LOGIT_TABLE_BITS);
        assign logit_rom[gi] = ENTRY;
    end

    // ------------------------------------------------------------------
    // Controller. After reset it sweeps the RAM to zero, then handles one
    // voxel at a time: IDLE takes the transfer and starts the RAM read,
    // CALC fuses the label and looks up the logit, WRITE clamps the
    // log-odds, writes the voxel back and loads the output register.
    // WRITE waits while the output register still holds an untaken result.
    // ------------------------------------------------------------------
    vlof_state_t                state_reg;
    vlof_state_t                state_next;
    logic [VOXEL_ADDR_BITS-1:0] clr_addr_reg;
    logic [VOXEL_ADDR_BITS-1:0] clr_addr_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       in_accept;
    logic                       commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        in_ready      = 1'b0;
        commit        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {VOXEL_ADDR_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input capture. The blend product (P - 1/2) * w is formed on the way
    // into its register so that CALC only adds, shifts and clamps.
    // ------------------------------------------------------------------
    logic [VOXEL_ADDR_BITS-1:0] addr_reg;
    logic [LABEL_BITS-1:0]      pred_reg;
    logic signed [33:0]         prod_reg;
    logic signed [16:0]         prob_diff;
    logic signed [16:0]         weight_s;

    assign prob_diff = $signed({1'b0, (pred_class != '0) ? occ_prob_reg : free_prob_reg})
                       - $signed(HALF_Q16);
    assign weight_s  = $signed({1'b0, obs_weight});

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            addr_reg <= voxel_addr;
            pred_reg <= pred_class;
            prod_reg <= prob_diff * weight_s;
        end
    end

    // ------------------------------------------------------------------
    // Voxel RAM
    // ------------------------------------------------------------------
    logic                       ram_we;
    logic [VOXEL_ADDR_BITS-1:0] ram_waddr;
    logic [WORD_BITS-1:0]       ram_wdata;
    logic [WORD_BITS-1:0]       ram_rdata;
    logic [WORD_BITS-1:0]       word_new;

    assign ram_we    = (state_reg == ST_CLEAR) || commit;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : word_new;

    vlof_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_voxel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (voxel_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // CALC: label fusion and logit lookup.
    // ------------------------------------------------------------------
    logic [LABEL_BITS-1:0] old_label;
    logic [15:0]           old_weight;
    logic signed [15:0]    old_lo;
    logic                  old_seen;
    logic [16:0]           weight_sum;
    logic [LABEL_BITS-1:0] fused_label;
    logic [15:0]           fused_weight;
    logic signed [34:0]    blend_num;
    logic signed [34:0]    blend_shift;
    logic [15:0]           p16;

    assign {old_seen, old_lo, old_weight, old_label} = ram_rdata;
    assign weight_sum = {1'b0, old_weight} + {1'b0, label_step_reg};

    always_comb
    begin
        fused_label  = old_label;
        fused_weight = old_weight;
        if (pred_reg != '0)
        begin
            if (pred_reg == old_label)
            begin
                // Same class: strengthen, saturating at the cap.
                fused_weight = (weight_sum < {1'b0, weight_cap_reg}) ? weight_sum[15:0]
                                                                     : weight_cap_reg;
            end
            else if (old_weight < label_step_reg)
            begin
                // A weaker stored class is overturned by the new one.
                fused_label  = pred_reg;
                fused_weight = label_step_reg - old_weight;
            end
            else
            begin
                fused_weight = old_weight - label_step_reg;
            end
        end
    end

    // Blended probability in Q0.16, clamped to the unit interval.
    assign blend_num   = BLEND_BIAS + 35'(prod_reg);
    assign blend_shift = blend_num >>> 15;

    always_comb
    begin
        if (blend_num < 0)
        begin
            p16 = '0;
        end
        else if (blend_shift > 35'sd65535)
        begin
            p16 = 16'hFFFF;
        end
        else
        begin
            p16 = blend_shift[15:0];
        end
    end

    logic [LABEL_BITS-1:0] fused_label_reg;
    logic [15:0]           fused_weight_reg;
    logic signed [15:0]    old_lo_reg;
    logic signed [15:0]    logit_reg;
    logic                  seen_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            fused_label_reg  <= fused_label;
            fused_weight_reg <= fused_weight;
            old_lo_reg       <= old_lo;
            logit_reg        <= logit_rom[p16[15 -: LOGIT_TABLE_BITS]];
            seen_reg         <= old_seen;
        end
    end

    // ------------------------------------------------------------------
    // WRITE: log-odds accumulation and clamp. The upper bound is applied
    // last, so it wins when the bounds cross.
    // ------------------------------------------------------------------
    logic signed [16:0] lo_sum;
    logic signed [15:0] lo_new;

    assign lo_sum = 17'(old_lo_reg) + 17'(logit_reg);

    always_comb
    begin
        if (lo_sum > 17'(max_lo_reg))
        begin
            lo_new = max_lo_reg;
        end
        else if (lo_sum < 17'(min_lo_reg))
        begin
            lo_new = min_lo_reg;
        end
        else
        begin
            lo_new = lo_sum[15:0];
        end
        if (min_lo_reg > max_lo_reg)
        begin
            lo_new = max_lo_reg;
        end
    end

    assign word_new = {1'b1, lo_new, fused_weight_reg, fused_label_reg};

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [VOXEL_ADDR_BITS-1:0] out_addr_reg;
    logic [LABEL_BITS-1:0]      out_label_reg;
    logic [15:0]                out_weight_reg;
    logic signed [15:0]         out_lo_reg;
    logic                       out_seen_reg;

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_addr_reg   <= addr_reg;
            out_label_reg  <= fused_label_reg;
            out_weight_reg <= fused_weight_reg;
            out_lo_reg     <= lo_new;
            out_seen_reg   <= seen_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_addr         = out_addr_reg;
    assign out_label        = out_label_reg;
    assign out_label_weight = out_weight_reg;
    assign out_log_odds     = out_lo_reg;
    assign was_observed     = out_seen_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A result appears only when a write-back has just completed.
    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result appeared without a write-back");

    // No input is taken while the RAM is still being swept.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("input taken during the RAM sweep");

    // An accepted item always moves on to the fusion stage.
    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_CALC))
        else $error("accepted item did not enter the fusion stage");

    // The write-back never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_valid_reg || out_ready))
        else $error("waiting result overwritten");

endmodule

>>> verif/voxel_label_occupancy_fusion_checker.sv
// ----------------------------------------------------------------------------
// Voxel fusion checker
// Watches the configuration port and both channels of the voxel fusion block.
// It keeps its own copy of the voxel store and the registers. It predicts every
// voxel update and compares each returned update with the oldest prediction.
// ----------------------------------------------------------------------------
module voxel_label_occupancy_fusion_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [vlof_pkg::APB_ADDR_BITS-1:0]       paddr,
    input  logic [vlof_pkg::APB_DATA_BITS-1:0]       pwdata,
    input  logic                                     pready,
    input  logic                                     in_valid,
    input  logic                                     in_ready,
    input  logic [vlof_pkg::VOXEL_ADDR_BITS_DEF-1:0] voxel_addr,
    input  logic [vlof_pkg::LABEL_BITS_DEF-1:0]      pred_class,
    input  logic [15:0]                              obs_weight,
    input  logic                                     out_valid,
    input  logic                                     out_ready,
    input  logic [vlof_pkg::VOXEL_ADDR_BITS_DEF-1:0] out_addr,
    input  logic [vlof_pkg::LABEL_BITS_DEF-1:0]      out_label,
    input  logic [15:0]                              out_label_weight,
    input  logic signed [15:0]                       out_log_odds,
    input  logic                                     was_observed,
    output int                                       mismatches,
    output int                                       results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import vlof_pkg::*;

    localparam int      ADDR_BITS    = VOXEL_ADDR_BITS_DEF;
    localparam int      LBL_BITS     = LABEL_BITS_DEF;
    localparam int      TABLE_BITS   = LOGIT_TABLE_BITS_DEF;
    localparam int      TABLE_SIZE   = 1 << TABLE_BITS;
    localparam int      VOXEL_COUNT  = 1 << ADDR_BITS;
    localparam longint  LN2_FRACTION = 45426;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [LBL_BITS-1:0]  label;
        logic [15:0]          weight;
        logic signed [15:0]   log_odds;
        logic                 seen;
    } voxel_update_t;

    // Shadow of the voxel store; all zero, as after the clearing sweep.
    bit [LBL_BITS-1:0]  label_store    [VOXEL_COUNT];
    bit [15:0]          weight_store   [VOXEL_COUNT];
    bit signed [15:0]   log_odds_store [VOXEL_COUNT];
    bit                 seen_store     [VOXEL_COUNT];

    logic signed [15:0] logit_lut [TABLE_SIZE];

    logic [15:0]        step_q88;
    logic [15:0]        cap_q88;
    logic [15:0]        occ_prob;
    logic [15:0]        free_prob;
    logic signed [15:0] lo_bound;
    logic signed [15:0] hi_bound;

    voxel_update_t      pending_updates [$];

    // Base-2 logarithm with 16 fraction bits, by repeated squaring.
    function automatic longint log2_fixed(input int unsigned x);
        int unsigned     shifted;
        int              exponent;
        longint unsigned sq;
        longint          acc;
        if (x == 0)
        begin
            return 0;
        end
        shifted  = x;
        exponent = 0;
        while (shifted > 1)
        begin
            shifted = shifted >> 1;
            exponent++;
        end
        sq  = (longint'(x) << 30) >> exponent;
        acc = longint'(exponent) * 65536;
        for (int b = 15; b >= 0; b--)
        begin
            sq = (sq * sq) >> 30;
            if (sq >= (64'd2 << 30))
            begin
                sq  = sq >> 1;
                acc = acc + (longint'(1) << b);
            end
        end
        return acc;
    endfunction

    // Logit of each bin midpoint, rounded half away from zero to Q8.8.
    initial
    begin : build_logit_lut
        int unsigned     num_a;
        int unsigned     num_b;
        longint          scaled;
        longint unsigned mag;
        longint          q;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            num_a  = 2 * i + 1;
            num_b  = 2 * TABLE_SIZE - num_a;
            scaled = (log2_fixed(num_a) - log2_fixed(num_b)) * LN2_FRACTION;
            mag    = (scaled < 0) ? -scaled : scaled;
            q      = longint'((mag + (64'd1 << 23)) >> 24);
            if (scaled < 0)
            begin
                q = -q;
            end
            if (q > 32767)
            begin
                q = 32767;
            end
            if (q < -32768)
            begin
                q = -32768;
            end
            logit_lut[i] = q[15:0];
        end
    end

    // Fuses one observation into the shadow store and returns the new voxel.
    task automatic fuse_observation(input logic [ADDR_BITS-1:0] addr_in,
                                    input logic [LBL_BITS-1:0] label_in,
                                    input logic [15:0] weight_in,
                                    output voxel_update_t upd);
        logic [LBL_BITS-1:0] label_now;
        logic [15:0]         weight_now;
        logic [16:0]         weight_sum;
        longint              prob;
        longint              obs;
        longint              blend;
        longint              p16;
        int                  fused;
        label_now  = label_store[addr_in];
        weight_now = weight_store[addr_in];
        if (label_in != '0)
        begin
            if (label_in == label_now)
            begin
                weight_sum = {1'b0, weight_now} + step_q88;
                weight_now = (weight_sum < cap_q88) ? weight_sum[15:0] : cap_q88;
            end
            else if (weight_now < step_q88)
            begin
                weight_now = step_q88 - weight_now;
                label_now  = label_in;
            end
            else
            begin
                weight_now = weight_now - step_q88;
            end
        end

        prob  = (label_in != '0) ? occ_prob : free_prob;
        obs   = weight_in;
        blend = (longint'(1) << 30) + 16384 + (prob - 32768) * obs;
        p16   = (blend < 0) ? 0 : (blend >>> 15);
        if (p16 > 65535)
        begin
            p16 = 65535;
        end

        fused = int'(log_odds_store[addr_in]) + int'(logit_lut[p16 >> (16 - TABLE_BITS)]);
        if (fused < lo_bound)
        begin
            fused = lo_bound;
        end
        if (fused > hi_bound)
        begin
            fused = hi_bound;
        end

        upd.addr     = addr_in;
        upd.label    = label_now;
        upd.weight   = weight_now;
        upd.log_odds = fused[15:0];
        upd.seen     = seen_store[addr_in];

        label_store[addr_in]    = label_now;
        weight_store[addr_in]   = weight_now;
        log_odds_store[addr_in] = fused[15:0];
        seen_store[addr_in]     = 1'b1;
    endtask

    function automatic bit field_differs(input string field, input longint want,
                                         input longint got);
        if (want == got)
        begin
            return 1'b0;
        end
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        voxel_update_t want;
        voxel_update_t fresh;
        int            bad;
        if (!rst_n)
        begin
            step_q88     = LABEL_STEP_RST;
            cap_q88      = WEIGHT_CAP_RST;
            occ_prob     = OCC_PROB_RST;
            free_prob    = FREE_PROB_RST;
            lo_bound     = MIN_LOG_ODDS_RST;
            hi_bound     = MAX_LOG_ODDS_RST;
            pending_updates.delete();
            mismatches   <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_index_t'(paddr >> 2))
                    REG_LABEL_STEP:   step_q88  = pwdata[15:0];
                    REG_WEIGHT_CAP:   cap_q88   = pwdata[15:0];
                    REG_OCC_PROB:     occ_prob  = pwdata[15:0];
                    REG_FREE_PROB:    free_prob = pwdata[15:0];
                    REG_MIN_LOG_ODDS: lo_bound  = pwdata[15:0];
                    REG_MAX_LOG_ODDS: hi_bound  = pwdata[15:0];
                    default:          ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (pending_updates.size() == 0)
                begin
                    $display("%0t: unexpected update, expected none, actual voxel %0d",
                             $time, out_addr);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = pending_updates.pop_front();
                    bad  = 0;
                    bad += field_differs("out_addr", want.addr, out_addr);
                    bad += field_differs("out_label", want.label, out_label);
                    bad += field_differs("out_label_weight", want.weight, out_label_weight);
                    bad += field_differs("out_log_odds", want.log_odds, out_log_odds);
                    bad += field_differs("was_observed", want.seen, was_observed);
                    mismatches <= mismatches + bad;
                end
            end

            if (in_valid && in_ready)
            begin
                fuse_observation(voxel_addr, pred_class, obs_weight, fresh);
                pending_updates.push_back(fresh);
            end
        end
    end

endmodule

>>> verif/voxel_label_occupancy_fusion_test.sv
// ----------------------------------------------------------------------------
// Voxel fusion testbench
// Drives voxel observations and register settings into the voxel label and
// occupancy fusion block, with random idling on both channels, and reports
// the verdict that the checker beside the block arrives at.
// ----------------------------------------------------------------------------
module voxel_label_occupancy_fusion_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vlof_pkg::*;

    // The block sweeps its whole store after reset before it takes the first
    // transfer, so the limit covers that sweep plus every item stalled on
    // both sides, several times over.
    localparam int         LIMIT_CYCLES    = 600000;
    localparam int         PHASE_COUNT     = 8;
    localparam int         PHASE_ITEMS     = 150;
    localparam int         TAIL_ITEMS      = 100;
    localparam int         SETTLE_CYCLES   = 6;
    localparam int         HOT_COUNT       = 6;
    // Register index just past the last real register; writes there are void.
    localparam logic [2:0] REG_SPARE_INDEX = 3'd6;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [APB_ADDR_BITS-1:0]       paddr;
    logic [APB_DATA_BITS-1:0]       pwdata;
    logic [APB_DATA_BITS-1:0]       prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_ready;
    logic [VOXEL_ADDR_BITS_DEF-1:0] voxel_addr;
    logic [LABEL_BITS_DEF-1:0]      pred_class;
    logic [15:0]                    obs_weight;
    logic                           out_valid;
    logic                           out_ready;
    logic [VOXEL_ADDR_BITS_DEF-1:0] out_addr;
    logic [LABEL_BITS_DEF-1:0]      out_label;
    logic [15:0]                    out_label_weight;
    logic signed [15:0]             out_log_odds;
    logic                           was_observed;

    int                             mismatches;
    int                             results_seen;
    int                             items_sent  = 0;
    int                             cycle_count = 0;
    int                             idle_pct    = 30;
    bit                             quiet_tail  = 1'b0;
    logic [15:0]                    last_addr   = '0;
    logic [15:0]                    hot_voxels [HOT_COUNT];

    voxel_label_occupancy_fusion dut (.*);

    voxel_label_occupancy_fusion_checker checker_inst (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost update ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stretches of ready and stall bursts follow each
    // other. In the tail of the run no new stall burst starts.
    initial
    begin : sink_pacing
        int hold;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (quiet_tail || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                hold = $urandom_range(1, 30);
            end
            else
            begin
                out_ready <= 1'b0;
                hold = $urandom_range(1, 13);
            end
            repeat (hold) @(posedge clk);
        end
    end

    // One observation transfer. Valid stays high until the block takes the
    // item; afterwards the sender may go idle for a burst of cycles.
    task automatic send_voxel(input logic [15:0] addr, input logic [7:0] label,
                              input logic [15:0] weight);
        in_valid   <= 1'b1;
        voxel_addr <= addr;
        pred_class <= label;
        obs_weight <= weight;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (!quiet_tail && $urandom_range(1, 100) <= idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Holds the sender back until every outstanding update has come back,
    // then lets the pipeline settle so that the block is truly idle.
    task automatic drain_updates();
        in_valid <= 1'b0;
        while (results_seen != items_sent)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One write transfer: setup cycle, then access cycle until pready. The
    // select is left high so that writes can follow back to back.
    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
    endtask

    // Register settings per phase: the defaults, two sets of extremes (the
    // second with the lower clamp above the upper one), a moderate set that
    // saturates the label weight quickly, and random sets after that.
    task automatic configure_phase(input int phase);
        logic [15:0]        step;
        logic [15:0]        cap;
        logic [15:0]        occ;
        logic [15:0]        fre;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        case (phase)
            0:
            begin
                step = LABEL_STEP_RST;
                cap  = WEIGHT_CAP_RST;
                occ  = OCC_PROB_RST;
                fre  = FREE_PROB_RST;
                lo   = MIN_LOG_ODDS_RST;
                hi   = MAX_LOG_ODDS_RST;
            end
            1:
            begin
                step = 16'hFFFF;
                cap  = 16'h0000;
                occ  = 16'hFFFF;
                fre  = 16'h0000;
                lo   = -16'sd32768;
                hi   = 16'sd32767;
            end
            2:
            begin
                step = 16'h0000;
                cap  = 16'hFFFF;
                occ  = 16'h0000;
                fre  = 16'hFFFF;
                lo   = 16'sd32767;
                hi   = -16'sd32768;
            end
            3:
            begin
                step = 16'd300;
                cap  = 16'd1000;
                occ  = 16'd60000;
                fre  = 16'd10000;
                lo   = -16'sd2000;
                hi   = 16'sd2000;
            end
            default:
            begin
                step = $urandom_range(0, 1) ? 16'($urandom_range(0, 1024)) : 16'($urandom);
                cap  = 16'($urandom);
                occ  = 16'($urandom);
                fre  = 16'($urandom);
                lo   = $urandom_range(0, 1) ? -16'($urandom_range(0, 4000)) : 16'($urandom);
                hi   = $urandom_range(0, 1) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
            end
        endcase
        write_register(REG_LABEL_STEP, step);
        write_register(REG_WEIGHT_CAP, cap);
        write_register(REG_OCC_PROB, occ);
        write_register(REG_FREE_PROB, fre);
        write_register(REG_MIN_LOG_ODDS, lo);
        write_register(REG_MAX_LOG_ODDS, hi);
        // A write past the last register must leave every setting alone.
        write_register(REG_SPARE_INDEX, 16'($urandom));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random observation. Most items land on a few hot voxels, often the same
    // one back to back, so that labels compete and the log-odds reach their
    // clamps; the rest spread over the whole store.
    task automatic send_random_item();
        logic [15:0] addr;
        logic [7:0]  label;
        logic [15:0] weight;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            addr = last_addr;
        end
        else if (pick < 75)
        begin
            addr = hot_voxels[$urandom_range(0, HOT_COUNT - 1)];
        end
        else if (pick < 92)
        begin
            addr = 16'($urandom);
        end
        else
        begin
            addr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end

        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            label = 8'd0;
        end
        else if (pick < 75)
        begin
            label = 8'($urandom_range(1, 3));
        end
        else if (pick < 90)
        begin
            label = 8'($urandom_range(1, 255));
        end
        else
        begin
            label = 8'hFF;
        end

        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            weight = 16'd32768;
        end
        else if (pick < 70)
        begin
            weight = 16'($urandom_range(0, 32768));
        end
        else if (pick < 88)
        begin
            weight = 16'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       weight = 16'd0;
                1:       weight = 16'd32767;
                default: weight = 16'hFFFF;
            endcase
        end

        last_addr = addr;
        send_voxel(addr, label, weight);
    endtask

    initial
    begin : stimulus
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        voxel_addr = '0;
        pred_class = '0;
        obs_weight = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset settings. The first transfer also waits
        // out the clearing sweep of the store.
        send_voxel(16'h0000, 8'd0, 16'd0);       // free space, zero weight: one half
        send_voxel(16'h0000, 8'd5, 16'd32768);   // label on an empty voxel takes over
        send_voxel(16'h0000, 8'd5, 16'd32768);   // matching label gains the step
        send_voxel(16'h0000, 8'd7, 16'd16384);   // rival label, weight above step: decay
        send_voxel(16'h0000, 8'd7, 16'd16384);   // weight equal to the step: down to zero
        send_voxel(16'h0000, 8'd7, 16'd16384);   // weight below the step: label replaced
        send_voxel(16'hFFFF, 8'hFF, 16'hFFFF);   // top voxel, top label, weight above one
        send_voxel(16'hFFFF, 8'd0, 16'hFFFF);    // free space with weight above one
        send_voxel(16'hFFFF, 8'd0, 16'd32768);
        for (int k = 0; k < 6; k++)
        begin
            send_voxel(16'd100, 8'd3, 16'd32768); // climbs into the upper clamp
        end
        for (int k = 0; k < 6; k++)
        begin
            send_voxel(16'd200, 8'd0, 16'd32768); // falls into the lower clamp
        end
        send_voxel(16'h5555, 8'hAA, 16'h5555);
        send_voxel(16'hAAAA, 8'h55, 16'h2AAA);

        // Random phases. Each one starts with the block drained, so every
        // register change happens while nothing is in flight.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_updates();
            configure_phase(phase);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 50;
            endcase
            for (int h = 0; h < HOT_COUNT; h++)
            begin
                hot_voxels[h] = 16'($urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == PHASE_COUNT - 1 && n >= PHASE_ITEMS - TAIL_ITEMS)
                begin
                    quiet_tail = 1'b1;
                end
                send_random_item();
            end
        end

        drain_updates();
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/vlof_pkg.sv
rtl/core/vlof_ram.sv
rtl/core/voxel_label_occupancy_fusion.sv
verif/voxel_label_occupancy_fusion_checker.sv
verif/voxel_label_occupancy_fusion_test.sv
